// ===== rtl/fhps_pkg.sv =====
package fhps_pkg;

  localparam int HASH_W    = 32;
  localparam int MSG_BYTES = 36;
  localparam int MSG_W     = MSG_BYTES * 8;
  localparam int MOD_BITS  = 4;
  localparam int MOD_CELLS = HASH_W / MOD_BITS;
  localparam int PIPE_LAT  = MSG_BYTES + MOD_CELLS;

  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;

  localparam logic [1:0] L3_NONE = 2'd0;
  localparam logic [1:0] L3_IPV4 = 2'd1;
  localparam logic [1:0] L3_IPV6 = 2'd2;

  function automatic logic [HASH_W-1:0] crc_byte(input logic [HASH_W-1:0] crc,
                                                 input logic [7:0] b);
    logic [HASH_W-1:0] c;
    c = crc ^ {24'h000000, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/fhps_crc_cell.sv =====
module fhps_crc_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        valid_in,
  input  logic [fhps_pkg::HASH_W-1:0] crc_in,
  input  logic [fhps_pkg::MSG_W-1:0]  msg_in,
  output logic                        valid_out,
  output logic [fhps_pkg::HASH_W-1:0] crc_out,
  output logic [fhps_pkg::MSG_W-1:0]  msg_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  // fold in the leading byte, advance the rest
  always_ff @(posedge clk) begin
    crc_out <= fhps_pkg::crc_byte(crc_in, msg_in[fhps_pkg::MSG_W-1 -: 8]);
    msg_out <= {msg_in[fhps_pkg::MSG_W-9:0], 8'h00};
  end

endmodule

// ===== rtl/fhps_mod_cell.sv =====
module fhps_mod_cell #(
  parameter int STEP  = 0,
  parameter int REM_W = 5
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        valid_in,
  input  logic [fhps_pkg::HASH_W-1:0] hash_in,
  input  logic [REM_W-1:0]            rem_in,
  input  logic [REM_W-1:0]            count,
  output logic                        valid_out,
  output logic [fhps_pkg::HASH_W-1:0] hash_out,
  output logic [REM_W-1:0]            rem_out
);

  localparam int TOP_BIT = fhps_pkg::HASH_W - 1 - STEP * fhps_pkg::MOD_BITS;

  logic [REM_W-1:0] rem_next;

  always_comb begin
    logic [REM_W:0] t;
    rem_next = rem_in;
    for (int i = 0; i < fhps_pkg::MOD_BITS; i++) begin
      t = {rem_next, hash_in[TOP_BIT - i]};
      if (t >= {1'b0, count}) begin
        t = t - {1'b0, count};
      end
      rem_next = t[REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    hash_out <= hash_in;
    rem_out  <= rem_next;
  end

endmodule

// ===== rtl/flow_hash_port_steering.sv =====
// Channel   Handshake      Fields
// command   start / busy   l3_kind has_ports src_addr_high src_addr_low
//                          dst_addr_high dst_addr_low src_port_value dst_port_value
// config    cfg_we         cfg_wdata (port_count)
// result    done           flow_hash out_port
//
// One transfer in per cycle while busy is low.
// Each result passes through a row of 36 byte-wide CRC cells followed by 8 cells
// that each take four hash bits of the remainder by the port count.
// busy is high only while rst is high. Results cannot be held off: done
// marks each one for a single cycle.
module flow_hash_port_steering #(
  parameter int MAX_OUT_PORTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  l3_kind,
  input  logic        has_ports,
  input  logic [63:0] src_addr_high,
  input  logic [63:0] src_addr_low,
  input  logic [63:0] dst_addr_high,
  input  logic [63:0] dst_addr_low,
  input  logic [15:0] src_port_value,
  input  logic [15:0] dst_port_value,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  output logic        done,
  output logic [31:0] flow_hash,
  output logic [3:0]  out_port
);

  localparam int CNT_BITS = $clog2(MAX_OUT_PORTS + 1);
  localparam int REM_W    = (CNT_BITS > 5) ? CNT_BITS : 5;
  localparam int NB       = fhps_pkg::MSG_BYTES;
  localparam int NM       = fhps_pkg::MOD_CELLS;

  logic [4:0]       port_count;
  logic [REM_W-1:0] count_eff;
  logic             take;
  logic [fhps_pkg::MSG_W-1:0] msg_first;

  logic                        crc_v [0:NB];
  logic [fhps_pkg::HASH_W-1:0] crc_h [0:NB];
  logic [fhps_pkg::MSG_W-1:0]  crc_m [0:NB];

  logic                        mod_v [0:NM];
  logic [fhps_pkg::HASH_W-1:0] mod_h [0:NM];
  logic [REM_W-1:0]            mod_r [0:NM];

  assign busy = rst;
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      port_count <= 5'd1;
    end else if (cfg_we) begin
      port_count <= cfg_wdata;
    end
  end

  always_comb begin
    if (port_count == 5'd0) begin
      count_eff = REM_W'(1);
    end else if (32'(port_count) > MAX_OUT_PORTS) begin
      count_eff = REM_W'(MAX_OUT_PORTS);
    end else begin
      count_eff = REM_W'(port_count);
    end
  end

  // right-align the bytes; leading zeros leave a zero-seeded CRC unchanged
  always_comb begin
    case (l3_kind)
      fhps_pkg::L3_IPV4: begin
        if (has_ports) begin
          msg_first = {192'd0, src_addr_low[31:0], dst_addr_low[31:0],
                       src_port_value, dst_port_value};
        end else begin
          msg_first = {224'd0, src_addr_low[31:0], dst_addr_low[31:0]};
        end
      end
      fhps_pkg::L3_IPV6: begin
        if (has_ports) begin
          msg_first = {src_addr_high, src_addr_low, dst_addr_high, dst_addr_low,
                       src_port_value, dst_port_value};
        end else begin
          msg_first = {32'd0, src_addr_high, src_addr_low, dst_addr_high,
                       dst_addr_low};
        end
      end
      default: begin
        msg_first = '0;
      end
    endcase
  end

  assign crc_v[0] = take;
  assign crc_h[0] = '0;
  assign crc_m[0] = msg_first;

  for (genvar k = 0; k < NB; k++) begin : g_crc
    fhps_crc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (crc_v[k]),
      .crc_in    (crc_h[k]),
      .msg_in    (crc_m[k]),
      .valid_out (crc_v[k+1]),
      .crc_out   (crc_h[k+1]),
      .msg_out   (crc_m[k+1])
    );
  end

  assign mod_v[0] = crc_v[NB];
  assign mod_h[0] = crc_h[NB];
  assign mod_r[0] = '0;

  for (genvar j = 0; j < NM; j++) begin : g_mod
    fhps_mod_cell #(
      .STEP  (j),
      .REM_W (REM_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (mod_v[j]),
      .hash_in   (mod_h[j]),
      .rem_in    (mod_r[j]),
      .count     (count_eff),
      .valid_out (mod_v[j+1]),
      .hash_out  (mod_h[j+1]),
      .rem_out   (mod_r[j+1])
    );
  end

  assign done      = mod_v[NM];
  assign flow_hash = mod_h[NM];
  assign out_port  = 4'(mod_r[NM]);

  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, fhps_pkg::PIPE_LAT))
    else $error("result without a matching start");

  a_unknown_l3_zero: assert property (@(posedge clk) disable iff (rst)
    (done && $past(start && !busy && !(l3_kind == fhps_pkg::L3_IPV4 ||
                   l3_kind == fhps_pkg::L3_IPV6), fhps_pkg::PIPE_LAT))
    |-> (flow_hash == 32'd0 && out_port == 4'd0))
    else $error("non-zero hash for unknown L3");

  a_port_in_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (REM_W'(out_port) < count_eff))
    else $error("out_port not below port count");

endmodule

// ===== sim/flow_hash_port_steering_tb.sv =====
module flow_hash_port_steering_tb;

  localparam int N_OUT_PORTS = 16;
  localparam logic [1:0] L3_RSVD = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 160;

  typedef struct {
    logic [31:0] hash;
    logic [3:0]  port;
  } steer_t;

  class steer_scoreboard;
    logic [4:0] port_count;
    steer_t     expected_steer[$];
    int         errors;

    function new();
      port_count = 5'd1;
      errors = 0;
    endfunction

    function logic [31:0] crc32c_byte(logic [31:0] crc, logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'h0, b};
      for (int i = 0; i < 8; i++) begin
        if (c[0]) begin
          c = (c >> 1) ^ 32'h82F6_3B78;
        end else begin
          c = c >> 1;
        end
      end
      return c;
    endfunction

    // feed the low nbytes of v, most significant byte first
    function logic [31:0] crc32c_bytes(logic [31:0] crc, logic [63:0] v, int nbytes);
      logic [31:0] c;
      c = crc;
      for (int i = nbytes - 1; i >= 0; i--) begin
        c = crc32c_byte(c, v[i*8 +: 8]);
      end
      return c;
    endfunction

    function void note_header(logic [1:0] kind, logic hp, logic [63:0] sah,
                              logic [63:0] sal, logic [63:0] dah, logic [63:0] dal,
                              logic [15:0] sp, logic [15:0] dp);
      steer_t  s;
      logic    known;
      int      cnt;
      s.hash = 32'h0;
      known = 1'b1;
      case (kind)
        fhps_pkg::L3_IPV4: begin
          s.hash = crc32c_bytes(s.hash, {32'h0, sal[31:0]}, 4);
          s.hash = crc32c_bytes(s.hash, {32'h0, dal[31:0]}, 4);
        end
        fhps_pkg::L3_IPV6: begin
          s.hash = crc32c_bytes(s.hash, sah, 8);
          s.hash = crc32c_bytes(s.hash, sal, 8);
          s.hash = crc32c_bytes(s.hash, dah, 8);
          s.hash = crc32c_bytes(s.hash, dal, 8);
        end
        default: known = 1'b0;
      endcase
      if (known && hp) begin
        s.hash = crc32c_bytes(s.hash, {48'h0, sp}, 2);
        s.hash = crc32c_bytes(s.hash, {48'h0, dp}, 2);
      end
      cnt = int'(port_count);
      if (cnt == 0) cnt = 1;
      if (cnt > N_OUT_PORTS) cnt = N_OUT_PORTS;
      s.port = 4'(s.hash % 32'(cnt));
      expected_steer.push_back(s);
    endfunction

    function void check_result(logic [31:0] hash, logic [3:0] port);
      steer_t s;
      if (expected_steer.size() == 0) begin
        $error("result with nothing expected: flow_hash %h out_port %0d", hash, port);
        errors++;
        return;
      end
      s = expected_steer.pop_front();
      if (hash !== s.hash) begin
        $error("flow_hash: expected %h, got %h", s.hash, hash);
        errors++;
      end
      if (port !== s.port) begin
        $error("out_port: expected %0d, got %0d", s.port, port);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  l3_kind;
  logic        has_ports;
  logic [63:0] src_addr_high;
  logic [63:0] src_addr_low;
  logic [63:0] dst_addr_high;
  logic [63:0] dst_addr_low;
  logic [15:0] src_port_value;
  logic [15:0] dst_port_value;
  logic        cfg_we;
  logic [4:0]  cfg_wdata;
  logic        done;
  logic [31:0] flow_hash;
  logic [3:0]  out_port;

  steer_scoreboard sb;
  logic hdr_xfer;
  int   idle_cycles;

  flow_hash_port_steering #(
    .MAX_OUT_PORTS(N_OUT_PORTS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .l3_kind(l3_kind),
    .has_ports(has_ports),
    .src_addr_high(src_addr_high),
    .src_addr_low(src_addr_low),
    .dst_addr_high(dst_addr_high),
    .dst_addr_low(dst_addr_low),
    .src_port_value(src_port_value),
    .dst_port_value(dst_port_value),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .done(done),
    .flow_hash(flow_hash),
    .out_port(out_port)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    hdr_xfer = (start === 1'b1) && (busy === 1'b0);
    if (rst) begin
      sb.port_count = 5'd1;
    end else if (cfg_we) begin
      sb.port_count = cfg_wdata;
    end
    if (hdr_xfer) begin
      sb.note_header(l3_kind, has_ports, src_addr_high, src_addr_low,
                     dst_addr_high, dst_addr_low, src_port_value, dst_port_value);
    end
    if (done === 1'b1) begin
      sb.check_result(flow_hash, out_port);
    end
    if (hdr_xfer || done === 1'b1) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL flow_hash_port_steering");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_header(input logic [1:0] kind, input logic hp,
                             input logic [63:0] sah, input logic [63:0] sal,
                             input logic [63:0] dah, input logic [63:0] dal,
                             input logic [15:0] sp, input logic [15:0] dp);
    start = 1'b1;
    l3_kind = kind;
    has_ports = hp;
    src_addr_high = sah;
    src_addr_low = sal;
    dst_addr_high = dah;
    dst_addr_low = dal;
    src_port_value = sp;
    dst_port_value = dp;
    do begin
      @(negedge clk);
    end while (!hdr_xfer);
  endtask

  // drive junk on the fields while start is low
  task automatic idle_for(input int n);
    if (n > 0) begin
      start = 1'b0;
      repeat (n) begin
        l3_kind = 2'($urandom);
        has_ports = 1'($urandom);
        src_addr_high = rand64();
        src_addr_low = rand64();
        dst_addr_high = rand64();
        dst_addr_low = rand64();
        src_port_value = 16'($urandom);
        dst_port_value = 16'($urandom);
        @(negedge clk);
      end
    end
  endtask

  task automatic send_random_header();
    int          r;
    logic [1:0]  kind;
    logic [15:0] sp;
    logic [15:0] dp;
    r = $urandom_range(0, 15);
    if (r == 0) kind = fhps_pkg::L3_NONE;
    else if (r == 1) kind = L3_RSVD;
    else if (r < 9) kind = fhps_pkg::L3_IPV4;
    else kind = fhps_pkg::L3_IPV6;
    sp = 16'($urandom);
    dp = 16'($urandom);
    if ($urandom_range(0, 7) == 0) sp = 16'hFFFF;
    if ($urandom_range(0, 7) == 0) dp = 16'h0000;
    send_header(kind, $urandom_range(0, 3) != 0, rand64(), rand64(), rand64(),
                rand64(), sp, dp);
  endtask

  task automatic drain();
    start = 1'b0;
    while (sb.expected_steer.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_port_count(input logic [4:0] v);
    drain();
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_wdata = 5'($urandom);
  endtask

  task automatic run_directed();
    logic [63:0] ones;
    ones = '1;
    send_header(fhps_pkg::L3_NONE, 1'b1, ones, ones, ones, ones, 16'hFFFF, 16'hFFFF);
    send_header(fhps_pkg::L3_NONE, 1'b0, 64'h0, 64'h0, 64'h0, 64'h0, 16'h0, 16'h0);
    send_header(L3_RSVD, 1'b1, ones, ones, ones, ones, 16'hFFFF, 16'hFFFF);
    send_header(L3_RSVD, 1'b0, rand64(), rand64(), rand64(), rand64(), 16'h1234, 16'h0050);
    send_header(fhps_pkg::L3_IPV4, 1'b0, 64'h0, 64'h0, 64'h0, 64'h0, 16'h0, 16'h0);
    send_header(fhps_pkg::L3_IPV4, 1'b1, 64'h0, 64'h0, 64'h0, 64'h0, 16'h0, 16'h0);
    send_header(fhps_pkg::L3_IPV4, 1'b1, ones, ones, ones, ones, 16'hFFFF, 16'hFFFF);
    send_header(fhps_pkg::L3_IPV4, 1'b0, ones, ones, ones, ones, 16'hFFFF, 16'hFFFF);
    idle_for(2);
    send_header(fhps_pkg::L3_IPV4, 1'b1, ones, 64'hFFFF_FFFF_0A00_0001, ones,
                64'hDEAD_0000_C0A8_0101, 16'h0400, 16'h0050);
    send_header(fhps_pkg::L3_IPV4, 1'b1, 64'h0, 64'h0000_0000_0A00_0001, 64'h0,
                64'h0000_0000_C0A8_0101, 16'h0400, 16'h0050);
    send_header(fhps_pkg::L3_IPV4, 1'b1, 64'h0, 64'h0, 64'h0, 64'h0, 16'hFFFF, 16'h0000);
    send_header(fhps_pkg::L3_IPV6, 1'b0, 64'h0, 64'h0, 64'h0, 64'h0, 16'h0, 16'h0);
    send_header(fhps_pkg::L3_IPV6, 1'b1, 64'h0, 64'h0, 64'h0, 64'h0, 16'h0, 16'h0);
    send_header(fhps_pkg::L3_IPV6, 1'b1, ones, ones, ones, ones, 16'hFFFF, 16'hFFFF);
    send_header(fhps_pkg::L3_IPV6, 1'b0, ones, ones, ones, ones, 16'hFFFF, 16'hFFFF);
    idle_for(5);
    send_header(fhps_pkg::L3_IPV6, 1'b1, 64'h2001_0DB8_0000_0000, 64'h0000_0000_0000_0001,
                64'hFE80_0000_0000_0000, 64'h0211_22FF_FE33_4455, 16'h01BB, 16'hC000);
    send_header(fhps_pkg::L3_IPV6, 1'b1, 64'h0, 64'h0, 64'h0, 64'h0, 16'h0000, 16'hFFFF);
    send_header(fhps_pkg::L3_IPV6, 1'b1, rand64(), rand64(), rand64(), rand64(),
                16'($urandom), 16'($urandom));
    send_header(fhps_pkg::L3_IPV4, 1'b1, rand64(), rand64(), rand64(), rand64(),
                16'($urandom), 16'($urandom));
    start = 1'b0;
  endtask

  initial begin
    logic [4:0] counts [N_PHASES];
    logic       burst;
    sb = new();
    hdr_xfer = 1'b0;
    idle_cycles = 0;
    rst = 1'b1;
    start = 1'b0;
    l3_kind = fhps_pkg::L3_NONE;
    has_ports = 1'b0;
    src_addr_high = 64'h0;
    src_addr_low = 64'h0;
    dst_addr_high = 64'h0;
    dst_addr_low = 64'h0;
    src_port_value = 16'h0;
    dst_port_value = 16'h0;
    cfg_we = 1'b0;
    cfg_wdata = 5'h0;
    counts[0] = 5'd16;
    counts[1] = 5'd0;
    counts[2] = 5'd31;
    counts[3] = 5'd17;
    counts[4] = 5'd1;
    for (int i = 5; i < N_PHASES; i++) counts[i] = 5'($urandom_range(0, 31));
    repeat (4) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    run_directed();
    write_port_count(5'd7);
    run_directed();

    for (int p = 0; p < N_PHASES; p++) begin
      write_port_count(counts[p]);
      burst = 1'b0;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ($urandom_range(0, 39) == 0) burst = ~burst;
        send_random_header();
        if (!burst) idle_for(gap_len());
      end
    end

    drain();
    repeat (fhps_pkg::PIPE_LAT + 10) @(negedge clk);
    if (sb.errors == 0 && sb.expected_steer.size() == 0) begin
      $display("PASS flow_hash_port_steering");
    end else begin
      $display("FAIL flow_hash_port_steering");
    end
    $finish;
  end

endmodule
